>>> hw/rtl/c3rm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the 3x3 conv / ReLU / max-pool stream unit.
// No dependencies; every other file in hw/rtl except c3rm_ram imports this package.
package c3rm_pkg;

    // Fixed geometry set by the item fields
    localparam int KERNEL_SIZE  = 3;
    localparam int FILTER_COUNT = 6;
    localparam int POOL_WIDTH   = 2;
    localparam int KK           = KERNEL_SIZE * KERNEL_SIZE;

    // Field and datapath widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int PIX_W  = 8;
    localparam int COEF_W = 24;
    localparam int FEAT_W = 24;
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int TAP_W  = $clog2(KK);
    localparam int FILT_W = $clog2(FILTER_COUNT);

    // Item opcodes
    localparam logic [OP_W-1:0] OP_COEF    = 2'd0;
    localparam logic [OP_W-1:0] OP_PIXEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [FEAT_W-1:0] FEAT_MAX = '1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Decoded coefficient slot
    typedef struct packed {
        logic              weight;
        logic              bias;
        logic [FILT_W-1:0] filt;
        logic [TAP_W-1:0]  tap;
    } slot_t;

    // Split a slot index into filter and tap, or flag a bias slot
    function automatic slot_t decode_slot(input logic [IDX_W-1:0] idx);
        slot_t s;
        int    f;
        s = '0;
        for (f = 0; f < FILTER_COUNT; f++) begin
            if (idx >= IDX_W'(f * KK) && idx < IDX_W'((f + 1) * KK)) begin
                s.weight = 1'b1;
                s.filt   = FILT_W'(f);
                s.tap    = TAP_W'(idx - IDX_W'(f * KK));
            end
            if (idx == IDX_W'(FILTER_COUNT * KK + f)) begin
                s.bias = 1'b1;
                s.filt = FILT_W'(f);
            end
        end
        return s;
    endfunction

    // Clamp negative sums to zero and saturate large ones
    function automatic logic [FEAT_W-1:0] relu_sat(input logic signed [SUM_W-1:0] s);
        if (s < 0)
            return '0;
        else if (s > $signed({{(SUM_W - FEAT_W){1'b0}}, FEAT_MAX}))
            return FEAT_MAX;
        else
            return s[FEAT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/c3rm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module c3rm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/c3rm_tap_cell.sv
`timescale 1ns / 1ps
// One window tap: holds a pixel that shifts to its left neighbor, the weights of every
// filter for this tap, and the registered products. Depends on c3rm_pkg.
module c3rm_tap_cell (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            shift_en,
    input  logic [c3rm_pkg::PIX_W-1:0]                      pix_in,
    output logic [c3rm_pkg::PIX_W-1:0]                      pix_out,
    input  logic                                            coef_we,
    input  logic [c3rm_pkg::FILT_W-1:0]                     coef_filt,
    input  c3rm_pkg::coef_t                                 coef_value,
    input  logic                                            prod_en,
    output c3rm_pkg::prod_t [c3rm_pkg::FILTER_COUNT-1:0]    prod
);
    import c3rm_pkg::*;

    logic [PIX_W-1:0] pix_reg;
    coef_t            coef_reg [FILTER_COUNT];
    prod_t            prod_reg [FILTER_COUNT];

    // Shift the window pixel in from the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (shift_en)
        begin
            pix_reg <= pix_in;
        end
    end

    // Hold the weights of this tap, one per filter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                coef_reg[f] <= '0;
            end
        end
        else
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                if (coef_we && coef_filt == FILT_W'(f))
                begin
                    coef_reg[f] <= coef_value;
                end
            end
        end
    end

    // Multiply the pixel by each weight
    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                prod_reg[f] <= $signed({1'b0, pix_reg}) * coef_reg[f];
            end
        end
    end

    assign pix_out = pix_reg;

    always_comb
    begin
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            prod[f] = prod_reg[f];
        end
    end

endmodule

>>> hw/rtl/conv3x3_relu_maxpool_stream_unit.sv
`timescale 1ns / 1ps
// Streaming 3x3 convolution (six filters) with ReLU and 2x2 max pooling.
// Depends on c3rm_pkg, c3rm_ram and c3rm_tap_cell.
//
// The unit takes one item per cycle: pixels in raster order, coefficient writes and
// frame restarts. The window is a chain of nine tap cells fed by a line RAM with one
// word per column; each cell multiplies its pixel by all six weights. Row sums, the
// bias add with ReLU, and the pool max against a RAM of running column maxima follow
// in registered stages a, b, c, d and e, and a result is then loaded into the output
// register from stage e for the pixel that closes a pooled cell. Input is held off
// only while a new result reaches the output register and the previous one has not
// been taken. After reset the line memory reads as zero through per-column valid
// bits, so there is no start-up pass.
module conv3x3_relu_maxpool_stream_unit #(
    parameter int IMAGE_SIZE = 28,
    localparam int CONV_SIZE  = IMAGE_SIZE - c3rm_pkg::KERNEL_SIZE + 1,
    localparam int POOLED     = CONV_SIZE / c3rm_pkg::POOL_WIDTH,
    localparam int POOL_IDX_W = (POOLED > 1) ? $clog2(POOLED) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [c3rm_pkg::OP_W-1:0]       opcode,
    input  logic [c3rm_pkg::IDX_W-1:0]      coef_index,
    input  c3rm_pkg::coef_t                 coef_value,
    input  logic [c3rm_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [POOL_IDX_W-1:0]           pool_row,
    output logic [POOL_IDX_W-1:0]           pool_col,
    output logic [c3rm_pkg::FEAT_W-1:0]     feature_a,
    output logic [c3rm_pkg::FEAT_W-1:0]     feature_b,
    output logic [c3rm_pkg::FEAT_W-1:0]     feature_c,
    output logic [c3rm_pkg::FEAT_W-1:0]     feature_d,
    output logic [c3rm_pkg::FEAT_W-1:0]     feature_e,
    output logic [c3rm_pkg::FEAT_W-1:0]     feature_f,
    output logic                            frame_done
);
    import c3rm_pkg::*;

    localparam int CNT_W  = $clog2(IMAGE_SIZE);
    localparam int LINE_W = (KERNEL_SIZE - 1) * PIX_W;
    localparam int POOL_W = FILTER_COUNT * FEAT_W;

    typedef struct packed {
        logic                  conv;
        logic                  first;
        logic                  last;
        logic                  done;
        logic [POOL_IDX_W-1:0] pr;
        logic [POOL_IDX_W-1:0] pc;
    } pos_t;

    // Handshake and position
    logic             advance;
    logic             accept;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] conv_r, conv_c;
    logic [CNT_W-2:0] pr_wide, pc_wide;
    pos_t             in_pos;

    // Stage a: after accept
    logic             a_pix_reg, a_coef_reg, a_line_ok_reg;
    logic [IDX_W-1:0] a_idx_reg;
    coef_t            a_val_reg;
    logic [PIX_W-1:0] a_px_reg;
    logic [CNT_W-1:0] a_col_reg;
    pos_t             a_pos_reg;

    // Stage b: window updated
    logic             b_pix_reg, b_coef_reg;
    logic [IDX_W-1:0] b_idx_reg;
    coef_t            b_val_reg;
    pos_t             b_pos_reg;
    slot_t            b_slot;

    // Stage c: products ready
    logic             c_v_reg;
    pos_t             c_pos_reg;
    coef_t            c_bias_reg [FILTER_COUNT];

    // Stage d: row sums
    logic                    d_v_reg;
    pos_t                    d_pos_reg;
    coef_t                   d_bias_reg [FILTER_COUNT];
    logic signed [ROW_W-1:0] d_rsum_reg [FILTER_COUNT][KERNEL_SIZE];
    logic signed [ROW_W-1:0] rsum_next [FILTER_COUNT][KERNEL_SIZE];

    // Stage e: features ready, pool entry being read
    logic                    e_v_reg;
    pos_t                    e_pos_reg;
    logic [FEAT_W-1:0]       e_feat_reg [FILTER_COUNT];
    logic [FEAT_W-1:0]       feat_next [FILTER_COUNT];
    logic signed [SUM_W-1:0] total [FILTER_COUNT];
    logic                    byp_reg, byp_next;
    logic [POOL_W-1:0]       byp_data_reg;

    // Output
    logic                  out_valid_reg;
    logic [POOL_IDX_W-1:0] out_row_reg, out_col_reg;
    logic                  out_done_reg;
    logic [POOL_W-1:0]     out_feat_reg;

    // Memories and cells
    coef_t                                bias_reg [FILTER_COUNT];
    logic [IMAGE_SIZE-1:0]                line_ok_reg;
    logic [LINE_W-1:0]                    line_rd;
    logic [LINE_W-1:0]                    line_q;
    logic [POOL_W-1:0]                    pool_rd;
    logic [POOL_W-1:0]                    pool_old;
    logic [POOL_W-1:0]                    pool_new;
    logic [PIX_W-1:0]                     win [KK];
    prod_t [FILTER_COUNT-1:0]             prod [KK];

    // Stall only when a result would land on a full, untaken output register
    assign advance  = !(e_v_reg && e_pos_reg.last && out_valid_reg && !out_ready);
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    // Conv and pool position of the incoming pixel
    always_comb
    begin
        conv_r        = row_reg - CNT_W'(KERNEL_SIZE - 1);
        conv_c        = col_reg - CNT_W'(KERNEL_SIZE - 1);
        pr_wide       = conv_r[CNT_W-1:1];
        pc_wide       = conv_c[CNT_W-1:1];
        in_pos.conv   = (row_reg >= CNT_W'(KERNEL_SIZE - 1))
                     && (col_reg >= CNT_W'(KERNEL_SIZE - 1))
                     && (pr_wide < (CNT_W - 1)'(POOLED))
                     && (pc_wide < (CNT_W - 1)'(POOLED));
        in_pos.first  = !conv_r[0] && !conv_c[0];
        in_pos.last   = conv_r[0] && conv_c[0];
        in_pos.pr     = pr_wide[POOL_IDX_W-1:0];
        in_pos.pc     = pc_wide[POOL_IDX_W-1:0];
        in_pos.done   = in_pos.last && (in_pos.pr == POOL_IDX_W'(POOLED - 1))
                     && (in_pos.pc == POOL_IDX_W'(POOLED - 1));
    end

    // Advance the raster position, or restart it
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (opcode)
            OP_RESTART:
            begin
                row_next = '0;
                col_next = '0;
            end
            OP_PIXEL:
            begin
                if (col_reg == CNT_W'(IMAGE_SIZE - 1))
                begin
                    col_next = '0;
                    row_next = (row_reg == CNT_W'(IMAGE_SIZE - 1)) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                row_next = row_reg;
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Line RAM: one word per column holds the previous image rows
    c3rm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (IMAGE_SIZE)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (advance && a_pix_reg),
        .wr_addr (a_col_reg),
        .wr_data ({a_px_reg, line_q[LINE_W-1:PIX_W]}),
        .rd_en   (accept && opcode == OP_PIXEL),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    // Unwritten columns read as zero
    assign line_q = a_line_ok_reg ? line_rd : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_ok_reg <= '0;
        end
        else if (advance && a_pix_reg)
        begin
            line_ok_reg[a_col_reg] <= 1'b1;
        end
    end

    // Stage a control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pix_reg  <= 1'b0;
            a_coef_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_pix_reg  <= accept && opcode == OP_PIXEL;
            a_coef_reg <= accept && opcode == OP_COEF;
        end
    end

    // Stage a payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_idx_reg     <= coef_index;
            a_val_reg     <= coef_value;
            a_px_reg      <= pixel;
            a_col_reg     <= col_reg;
            a_pos_reg     <= in_pos;
            a_line_ok_reg <= line_ok_reg[col_reg];
        end
    end

    // Stage b control and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_pix_reg  <= 1'b0;
            b_coef_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_pix_reg  <= a_pix_reg;
            b_coef_reg <= a_coef_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_idx_reg <= a_idx_reg;
            b_val_reg <= a_val_reg;
            b_pos_reg <= a_pos_reg;
        end
    end

    assign b_slot = decode_slot(b_idx_reg);

    // Tap cell chain: each cell hands its pixel to the left neighbor
    for (genvar t = 0; t < KK; t++)
    begin : g_tap
        localparam int TR = t / KERNEL_SIZE;
        localparam int TC = t % KERNEL_SIZE;
        logic [PIX_W-1:0] shift_in;

        if (TC == KERNEL_SIZE - 1)
        begin : g_edge
            if (TR < KERNEL_SIZE - 1)
            begin : g_line
                assign shift_in = line_q[TR*PIX_W +: PIX_W];
            end
            else
            begin : g_new
                assign shift_in = a_px_reg;
            end
        end
        else
        begin : g_inner
            assign shift_in = win[t+1];
        end

        c3rm_tap_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (advance && a_pix_reg),
            .pix_in     (shift_in),
            .pix_out    (win[t]),
            .coef_we    (advance && b_coef_reg && b_slot.weight
                         && b_slot.tap == TAP_W'(t)),
            .coef_filt  (b_slot.filt),
            .coef_value (b_val_reg),
            .prod_en    (advance && b_pix_reg && b_pos_reg.conv),
            .prod       (prod[t])
        );
    end

    // Bias registers, written in step with the weights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                bias_reg[f] <= '0;
            end
        end
        else if (advance && b_coef_reg && b_slot.bias)
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                if (b_slot.filt == FILT_W'(f))
                begin
                    bias_reg[f] <= b_val_reg;
                end
            end
        end
    end

    // Row sums of the products
    always_comb
    begin
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                rsum_next[f][r] = '0;
                for (int c = 0; c < KERNEL_SIZE; c++)
                begin
                    rsum_next[f][r] = rsum_next[f][r] + ROW_W'(prod[r*KERNEL_SIZE+c][f]);
                end
            end
        end
    end

    // Add bias and row sums, then clamp
    always_comb
    begin
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            total[f] = SUM_W'(d_bias_reg[f]);
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                total[f] = total[f] + SUM_W'(d_rsum_reg[f][r]);
            end
            feat_next[f] = relu_sat(total[f]);
        end
    end

    // Stages c, d, e control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            byp_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_v_reg <= b_pix_reg && b_pos_reg.conv;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            byp_reg <= byp_next;
        end
    end

    // Stages c, d, e payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_pos_reg    <= b_pos_reg;
            d_pos_reg    <= c_pos_reg;
            e_pos_reg    <= d_pos_reg;
            byp_data_reg <= pool_new;
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                c_bias_reg[f] <= bias_reg[f];
                d_bias_reg[f] <= c_bias_reg[f];
                e_feat_reg[f] <= feat_next[f];
                for (int r = 0; r < KERNEL_SIZE; r++)
                begin
                    d_rsum_reg[f][r] <= rsum_next[f][r];
                end
            end
        end
    end

    // Forward the entry being written when the next item reads the same column
    assign byp_next = e_v_reg && d_v_reg && (e_pos_reg.pc == d_pos_reg.pc);

    // Running max per pooled column
    c3rm_ram #(
        .WIDTH (POOL_W),
        .DEPTH (POOLED)
    ) u_pool_ram (
        .clk     (clk),
        .wr_en   (advance && e_v_reg),
        .wr_addr (e_pos_reg.pc),
        .wr_data (pool_new),
        .rd_en   (advance && d_v_reg),
        .rd_addr (d_pos_reg.pc),
        .rd_data (pool_rd)
    );

    assign pool_old = byp_reg ? byp_data_reg : pool_rd;

    // Take the max, or restart it on the first conv output of a cell
    always_comb
    begin
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            if (e_pos_reg.first || e_feat_reg[f] > pool_old[f*FEAT_W +: FEAT_W])
            begin
                pool_new[f*FEAT_W +: FEAT_W] = e_feat_reg[f];
            end
            else
            begin
                pool_new[f*FEAT_W +: FEAT_W] = pool_old[f*FEAT_W +: FEAT_W];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && e_v_reg && e_pos_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && e_v_reg && e_pos_reg.last)
        begin
            out_row_reg  <= e_pos_reg.pr;
            out_col_reg  <= e_pos_reg.pc;
            out_done_reg <= e_pos_reg.done;
            out_feat_reg <= pool_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pool_row   = out_row_reg;
    assign pool_col   = out_col_reg;
    assign frame_done = out_done_reg;
    assign feature_a  = out_feat_reg[0*FEAT_W +: FEAT_W];
    assign feature_b  = out_feat_reg[1*FEAT_W +: FEAT_W];
    assign feature_c  = out_feat_reg[2*FEAT_W +: FEAT_W];
    assign feature_d  = out_feat_reg[3*FEAT_W +: FEAT_W];
    assign feature_e  = out_feat_reg[4*FEAT_W +: FEAT_W];
    assign feature_f  = out_feat_reg[5*FEAT_W +: FEAT_W];

endmodule

>>> sim/conv3x3_relu_maxpool_stream_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 conv / ReLU / 2x2 max-pool unit.
// Depends on c3rm_pkg and the RTL top conv3x3_relu_maxpool_stream_unit.
module conv3x3_relu_maxpool_stream_unit_tb;
    import c3rm_pkg::*;

    localparam int IMG       = 28;
    localparam int CONV_N    = IMG - KERNEL_SIZE + 1;
    localparam int POOL_N    = CONV_N / POOL_WIDTH;
    localparam int SLOTS     = FILTER_COUNT * KK + FILTER_COUNT;
    localparam int BIAS_BASE = FILTER_COUNT * KK;
    localparam int WATCHDOG  = 5000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [COEF_W-1:0] val;
        logic [PIX_W-1:0]  px;
    } stim_item_t;

    typedef struct packed {
        logic [3:0]                          row;
        logic [3:0]                          col;
        logic [FILTER_COUNT-1:0][FEAT_W-1:0] feat;
        logic                                done;
    } pool_cell_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  coef_index;
    coef_t             coef_value;
    logic [PIX_W-1:0]  pixel;
    logic              out_valid;
    logic              out_ready;
    logic [3:0]        pool_row;
    logic [3:0]        pool_col;
    logic [FEAT_W-1:0] feature_a, feature_b, feature_c, feature_d, feature_e, feature_f;
    logic              frame_done;

    stim_item_t item_q[$];
    pool_cell_t cell_q[$];
    int         err_cnt;
    int         item_cnt;
    int         cell_cnt;
    int         frames_done;
    int         gap_left;
    int         burst_left;
    int         stall_pct;
    int         idle_cycles;
    int         cyc;

    // Predictor state
    logic signed [COEF_W-1:0] w_store[SLOTS];
    logic [PIX_W-1:0]         line_mem[KERNEL_SIZE-1][IMG];
    logic [PIX_W-1:0]         win[KERNEL_SIZE][KERNEL_SIZE];
    logic [FEAT_W-1:0]        pool_max[POOL_N][FILTER_COUNT];
    int                       p_row;
    int                       p_col;

    conv3x3_relu_maxpool_stream_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .coef_index(coef_index), .coef_value(coef_value), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready), .pool_row(pool_row),
        .pool_col(pool_col), .feature_a(feature_a), .feature_b(feature_b),
        .feature_c(feature_c), .feature_d(feature_d), .feature_e(feature_e),
        .feature_f(feature_f), .frame_done(frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (cell %0d)", what, got, want, cell_cnt);
        err_cnt++;
    endtask

    // Conv sum of one filter over the current window, with ReLU and saturation
    function automatic logic [FEAT_W-1:0] conv_feature(input int f);
        longint acc;
        int     m, n;
        acc = longint'(w_store[BIAS_BASE + f]);
        for (m = 0; m < KERNEL_SIZE; m++)
            for (n = 0; n < KERNEL_SIZE; n++)
                acc += longint'(win[m][n]) * longint'(w_store[f * KK + m * KERNEL_SIZE + n]);
        if (acc < 0)
            return '0;
        if (acc > longint'(FEAT_MAX))
            return FEAT_MAX;
        return acc[FEAT_W-1:0];
    endfunction

    // Advance the predictor by one accepted item
    task automatic predict_item(input stim_item_t it);
        pool_cell_t exp_cell;
        int         r, c, f, cr, cc, pr, pc;
        logic [FEAT_W-1:0] v;
        bit         first, last;
        if (it.op == OP_COEF)
        begin
            if (it.idx < SLOTS)
                w_store[it.idx] = it.val;
            return;
        end
        if (it.op == OP_RESTART)
        begin
            p_row = 0;
            p_col = 0;
            return;
        end
        if (it.op != OP_PIXEL)
            return;
        // shift the window and bring in the new column
        for (r = 0; r < KERNEL_SIZE; r++)
        begin
            for (c = 0; c + 1 < KERNEL_SIZE; c++)
                win[r][c] = win[r][c + 1];
            win[r][KERNEL_SIZE-1] = (r < KERNEL_SIZE - 1) ? line_mem[r][p_col] : it.px;
        end
        for (r = 0; r + 2 < KERNEL_SIZE; r++)
            line_mem[r][p_col] = line_mem[r + 1][p_col];
        line_mem[KERNEL_SIZE-2][p_col] = it.px;
        if (p_row >= KERNEL_SIZE - 1 && p_col >= KERNEL_SIZE - 1)
        begin
            cr = p_row - (KERNEL_SIZE - 1);
            cc = p_col - (KERNEL_SIZE - 1);
            pr = cr / POOL_WIDTH;
            pc = cc / POOL_WIDTH;
            if (pr < POOL_N && pc < POOL_N)
            begin
                first = (cr % POOL_WIDTH == 0) && (cc % POOL_WIDTH == 0);
                last  = (cr % POOL_WIDTH == POOL_WIDTH - 1) && (cc % POOL_WIDTH == POOL_WIDTH - 1);
                for (f = 0; f < FILTER_COUNT; f++)
                begin
                    v = conv_feature(f);
                    if (first || v > pool_max[pc][f])
                        pool_max[pc][f] = v;
                end
                if (last)
                begin
                    exp_cell.row  = 4'(pr);
                    exp_cell.col  = 4'(pc);
                    for (f = 0; f < FILTER_COUNT; f++)
                        exp_cell.feat[f] = pool_max[pc][f];
                    exp_cell.done = (pr == POOL_N - 1) && (pc == POOL_N - 1);
                    cell_q = {cell_q, exp_cell};
                end
            end
        end
        p_col++;
        if (p_col >= IMG)
        begin
            p_col = 0;
            p_row++;
            if (p_row >= IMG)
                p_row = 0;
        end
    endtask

    // Driver: bursts with random gaps, hold the item until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            opcode     <= OP_UNUSED;
            coef_index <= '0;
            coef_value <= '0;
            pixel      <= '0;
            gap_left   <= 0;
            burst_left <= 4;
            for (int i = 0; i < SLOTS; i++)
                w_store[i] = '0;
            for (int r = 0; r < KERNEL_SIZE - 1; r++)
                for (int c = 0; c < IMG; c++)
                    line_mem[r][c] = '0;
            for (int r = 0; r < KERNEL_SIZE; r++)
                for (int c = 0; c < KERNEL_SIZE; c++)
                    win[r][c] = '0;
            p_row = 0;
            p_col = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item(item_q.pop_front());
                item_cnt++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    in_valid   <= 1'b1;
                    opcode     <= item_q[0].op;
                    coef_index <= item_q[0].idx;
                    coef_value <= item_q[0].val;
                    pixel      <= item_q[0].px;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall on a shifting duty pattern, compare each taken cell
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_pct   <= 0;
            cyc         <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (cyc % 200 == 0)
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 85);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (out_valid && out_ready)
            begin
                if (cell_q.size() == 0)
                    report("unexpected cell", pool_row, -1);
                else
                begin
                    pool_cell_t want;
                    want = cell_q.pop_front();
                    if (pool_row !== want.row) report("pool_row", pool_row, want.row);
                    if (pool_col !== want.col) report("pool_col", pool_col, want.col);
                    if (feature_a !== want.feat[0]) report("feature_a", feature_a, want.feat[0]);
                    if (feature_b !== want.feat[1]) report("feature_b", feature_b, want.feat[1]);
                    if (feature_c !== want.feat[2]) report("feature_c", feature_c, want.feat[2]);
                    if (feature_d !== want.feat[3]) report("feature_d", feature_d, want.feat[3]);
                    if (feature_e !== want.feat[4]) report("feature_e", feature_e, want.feat[4]);
                    if (feature_f !== want.feat[5]) report("feature_f", feature_f, want.feat[5]);
                    if (frame_done !== want.done) report("frame_done", frame_done, want.done);
                    if (want.done) frames_done++;
                end
                cell_cnt++;
            end
            // watchdog on cycles with no handshake at all
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("watchdog expired with %0d items queued", item_q.size());
                $display("conv3x3_relu_maxpool_stream_unit verification failed");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [OP_W-1:0] op, input int idx, input int val,
                             input int px);
        stim_item_t it;
        it.op  = op;
        it.idx = IDX_W'(idx);
        it.val = COEF_W'(val);
        it.px  = PIX_W'(px);
        item_q = {item_q, it};
    endtask

    // Coefficient write with random filler in the unused fields
    task automatic push_coef(input int idx, input int val);
        push_item(OP_COEF, idx, val, $urandom_range(0, 255));
    endtask

    task automatic push_pixel(input int px);
        push_item(OP_PIXEL, $urandom_range(0, 63), $urandom, px);
    endtask

    // Hold the stream until every expected cell is out, then let the pipe empty
    task automatic drain();
        while (item_q.size() > 0 || cell_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Load all slots: 0 scaled-pixel weights, 1 extremes, 2 full random
    task automatic load_coefs(input int style);
        int v;
        for (int i = 0; i < SLOTS; i++)
        begin
            case (style)
                0: v = (i < BIAS_BASE) ? $urandom_range(0, 8400) - 4400
                                       : $urandom_range(0, 1 << 21) - (1 << 20);
                1: case ($urandom_range(0, 3))
                       0: v = -8388608;
                       1: v = 8388607;
                       2: v = 0;
                       default: v = $urandom_range(0, 16777215) - 8388608;
                   endcase
                default: v = $urandom_range(0, 16777215) - 8388608;
            endcase
            push_coef(i, v);
        end
        // out-of-range slots are ignored
        push_coef($urandom_range(SLOTS, 63), $urandom);
    endtask

    task automatic push_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 60) == 0)
                push_item(OP_UNUSED, $urandom_range(0, 63), $urandom, $urandom_range(0, 255));
            push_pixel(($urandom_range(0, 9) == 0) ? 255 * $urandom_range(0, 1)
                                                   : $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        err_cnt     = 0;
        item_cnt    = 0;
        cell_cnt    = 0;
        frames_done = 0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored opcode, out-of-range slots, coefficient extremes, restart
        push_item(OP_UNUSED, 63, -1, 255);
        push_coef(63, 8388607);
        push_coef(60, -8388608);
        push_coef(0, -8388608);
        push_coef(8, 8388607);
        push_coef(BIAS_BASE, 8388607);
        push_coef(SLOTS - 1, -8388608);
        push_item(OP_RESTART, 0, 0, 0);
        push_pixel(255);
        push_pixel(0);
        push_item(OP_RESTART, 63, -1, 255);
        drain();

        // Realistic weights over the first pooled rows
        load_coefs(0);
        push_item(OP_RESTART, 0, 0, 0);
        push_pixels(4 * IMG + 14);
        drain();

        // Extreme weights, restart mid-row, then a fresh pooled row
        load_coefs(1);
        push_pixels(IMG + 11);
        push_item(OP_RESTART, $urandom_range(0, 63), $urandom, $urandom_range(0, 255));
        push_pixels(4 * IMG);
        drain();

        $display("summary: %0d items accepted, %0d pooled cells checked, %0d frames closed",
                 item_cnt, cell_cnt, frames_done);
        $display("covered realistic and extreme weights, ignored items and mid-row restarts");
        if (err_cnt == 0)
            $display("conv3x3_relu_maxpool_stream_unit verification clean");
        else
            $display("conv3x3_relu_maxpool_stream_unit verification failed");
        $finish;
    end

endmodule
